>>> design/bdce_pkg.sv
package bdce_pkg;

   localparam int NUM_STAGES   = 5;
   localparam int EARLIEST_YEAR = 1900;
   localparam int DAYS_PER_YEAR = 365;
   localparam int SECS_PER_DAY = 24 * 60 * 60;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MIN = 60;
   localparam int LAST_HOUR    = 23;
   localparam int LAST_MINUTE  = 59;
   localparam int LAST_MONTH   = 12;
   // floor(n / 100) for n below 2^14 as (n * 5243) >> 19
   localparam int DIV100_MUL   = 5243;
   localparam int DIV100_SHIFT = 19;

   localparam int YEAR_W    = 14;
   localparam int FIELD_W   = 7;
   localparam int LEAPS_W   = 12;
   localparam int YDAY_W    = 9;
   localparam int BTOD_W    = 17;
   localparam int NTOD_W    = 18;
   localparam int ELAPSED_W = 38;

   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_YEAR,
      ERR_MONTH,
      ERR_DAY,
      ERR_HOUR,
      ERR_MINUTE,
      ERR_FUTURE
   } err_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
   } flow_type;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
      logic [8:0]  day_of_year;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } now_type;

   typedef struct packed {
      err_type             err;
      logic [YEAR_W-1:0]   year_diff;
      logic [LEAPS_W-1:0]  leaps_now;
      logic [LEAPS_W-1:0]  leaps_birth;
      logic [YDAY_W-1:0]   yday;
      logic [BTOD_W-1:0]   birth_tod;
   } front_type;

   function automatic logic [7:0] div100(input logic [YEAR_W-1:0] n);
      logic [26:0] prod;
      prod = 27'(n) * 27'(DIV100_MUL);
      return prod[26:DIV100_SHIFT];
   endfunction

   // leap years in 1..n, given q = n / 100
   function automatic logic [LEAPS_W-1:0] leaps_upto(input logic [YEAR_W-1:0] n,
                                                     input logic [7:0] q);
      logic [12:0] sum;
      sum = 13'(n >> 2) - 13'(q) + 13'(q >> 2);
      return sum[LEAPS_W-1:0];
   endfunction

   function automatic logic [8:0] days_before_month(input logic [6:0] month);
      logic [8:0] d;
      unique case (month)
         7'd2:    d = 9'd31;
         7'd3:    d = 9'd59;
         7'd4:    d = 9'd90;
         7'd5:    d = 9'd120;
         7'd6:    d = 9'd151;
         7'd7:    d = 9'd181;
         7'd8:    d = 9'd212;
         7'd9:    d = 9'd243;
         7'd10:   d = 9'd273;
         7'd11:   d = 9'd304;
         7'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

>>> design/bdce_flow.sv
module bdce_flow import bdce_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   output flow_type flow
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] en;

   // a stage loads when it is empty or its contents move on
   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   always_comb begin
      valid_in[0] = en[0] ? req_tvalid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign flow.en     = en;
   assign req_tready  = en[0];
   assign rsp_tvalid  = valid_ff[NUM_STAGES-1];

`ifndef SYNTHESIS
   a_fill_one: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !(rsp_tvalid && rsp_tready))
      |=> $countones(valid_ff) == $past($countones(valid_ff)) + 1)
      else $error("pipeline lost or duplicated a request on entry");
   a_drain_one: assert property (@(posedge clock) disable iff (reset)
      (!(req_tvalid && req_tready) && rsp_tvalid && rsp_tready)
      |=> $countones(valid_ff) + 1 == $past($countones(valid_ff)))
      else $error("pipeline lost or duplicated a request on exit");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result dropped while the receiver held off");
`endif

endmodule

>>> design/bdce_front.sv
module bdce_front import bdce_pkg::*; (
   input  logic               clock,
   input  flow_type           flow,
   input  now_type            now_cfg,
   input  logic [FIELD_W-1:0] birth_day,
   input  logic [FIELD_W-1:0] birth_month,
   input  logic [YEAR_W-1:0]  birth_year,
   input  logic [FIELD_W-1:0] birth_hour,
   input  logic [FIELD_W-1:0] birth_minute,
   output front_type          front_out
);

   // stage 1: range flags, future compare, divisions by 100, birth time of day
   logic [FIELD_W-1:0] day_ff, month_ff;
   logic [YEAR_W-1:0]  year_ff;
   logic [7:0]         year_q_ff, year_m1_q_ff, now_m1_q_ff;
   logic               year_bad_ff, month_bad_ff, hour_bad_ff, minute_bad_ff, future_ff;
   logic [BTOD_W-1:0]  btod_ff;

   logic               year_bad_in, month_bad_in, hour_bad_in, minute_bad_in, future_in;
   logic [BTOD_W-1:0]  btod_in;

   always_comb begin
      year_bad_in   = (birth_year > now_cfg.year) || (32'(birth_year) < EARLIEST_YEAR);
      month_bad_in  = (birth_month == '0) || (32'(birth_month) > LAST_MONTH);
      hour_bad_in   = 32'(birth_hour) > LAST_HOUR;
      minute_bad_in = 32'(birth_minute) > LAST_MINUTE;
      future_in = (birth_year == now_cfg.year) &&
         ((birth_month > 7'(now_cfg.month)) ||
          ((birth_month == 7'(now_cfg.month)) &&
           ((birth_day > 7'(now_cfg.day_of_month)) ||
            ((birth_day == 7'(now_cfg.day_of_month)) &&
             ((birth_hour > 7'(now_cfg.hour)) ||
              ((birth_hour == 7'(now_cfg.hour)) &&
               (birth_minute > 7'(now_cfg.minute))))))));
      btod_in = BTOD_W'(32'(birth_hour) * SECS_PER_HOUR + 32'(birth_minute) * SECS_PER_MIN);
   end

   always_ff @(posedge clock) begin
      if (flow.en[0]) begin
         day_ff        <= birth_day;
         month_ff      <= birth_month;
         year_ff       <= birth_year;
         year_q_ff     <= div100(birth_year);
         year_m1_q_ff  <= div100(birth_year - 1'b1);
         now_m1_q_ff   <= div100(now_cfg.year - 1'b1);
         year_bad_ff   <= year_bad_in;
         month_bad_ff  <= month_bad_in;
         hour_bad_ff   <= hour_bad_in;
         minute_bad_ff <= minute_bad_in;
         future_ff     <= future_in;
         btod_ff       <= btod_in;
      end
   end

   // stage 2: leap year, month length, error priority, leap counts, day of year
   logic        cent, leap, day_bad;
   logic [4:0]  mlen;
   logic [14:0] cent_prod;
   front_type   front_in, front_ff;

   always_comb begin
      cent_prod = 15'(year_q_ff) * 15'd100;
      cent      = (cent_prod == 15'(year_ff));
      leap      = ((year_ff[1:0] == 2'b00) && !cent) || (cent && (year_q_ff[1:0] == 2'b00));
      unique case (month_ff)
         7'd2:                      mlen = leap ? 5'd29 : 5'd28;
         7'd4, 7'd6, 7'd9, 7'd11:   mlen = 5'd30;
         default:                   mlen = 5'd31;
      endcase
      day_bad = (day_ff == '0) || (day_ff > 7'(mlen));

      priority if (year_bad_ff)   front_in.err = ERR_YEAR;
      else if (month_bad_ff)      front_in.err = ERR_MONTH;
      else if (day_bad)           front_in.err = ERR_DAY;
      else if (hour_bad_ff)       front_in.err = ERR_HOUR;
      else if (minute_bad_ff)     front_in.err = ERR_MINUTE;
      else if (future_ff)         front_in.err = ERR_FUTURE;
      else                        front_in.err = ERR_NONE;

      front_in.year_diff   = now_cfg.year - year_ff;
      front_in.leaps_now   = leaps_upto(now_cfg.year - 1'b1, now_m1_q_ff);
      front_in.leaps_birth = leaps_upto(year_ff - 1'b1, year_m1_q_ff);
      front_in.yday        = days_before_month(month_ff) + 9'(day_ff) - 9'd1
                             + 9'(leap && (month_ff > 7'd2));
      front_in.birth_tod   = btod_ff;
   end

   always_ff @(posedge clock) begin
      if (flow.en[1]) begin
         front_ff <= front_in;
      end
   end

   assign front_out = front_ff;

endmodule

>>> design/bdce_back.sv
module bdce_back import bdce_pkg::*; (
   input  logic                 clock,
   input  flow_type             flow,
   input  now_type              now_cfg,
   input  front_type            front_in,
   output logic                 date_ok,
   output err_type              error_kind,
   output logic [ELAPSED_W-1:0] elapsed_seconds
);

   // stage 3: signed day count between the two moments
   logic signed [24:0] days_in, days_ff;
   logic [22:0]        year_days;
   err_type            err3_ff, err4_ff;
   logic [BTOD_W-1:0]  btod3_ff, btod4_ff;

   always_comb begin
      year_days = 23'(32'(front_in.year_diff) * DAYS_PER_YEAR);
      days_in = $signed({2'b00, year_days})
              + $signed({13'b0, front_in.leaps_now})
              - $signed({13'b0, front_in.leaps_birth})
              + $signed({16'b0, now_cfg.day_of_year})
              - $signed({16'b0, front_in.yday});
   end

   always_ff @(posedge clock) begin
      if (flow.en[2]) begin
         days_ff  <= days_in;
         err3_ff  <= front_in.err;
         btod3_ff <= front_in.birth_tod;
      end
   end

   // stage 4: days to seconds, time of day now
   logic signed [42:0] prod_ff;
   logic [NTOD_W-1:0]  ntod_in, ntod_ff;

   always_comb begin
      ntod_in = NTOD_W'(32'(now_cfg.hour) * SECS_PER_HOUR
                      + 32'(now_cfg.minute) * SECS_PER_MIN + 32'(now_cfg.second));
   end

   always_ff @(posedge clock) begin
      if (flow.en[3]) begin
         prod_ff  <= 43'(days_ff) * 43'(SECS_PER_DAY);
         ntod_ff  <= ntod_in;
         err4_ff  <= err3_ff;
         btod4_ff <= btod3_ff;
      end
   end

   // stage 5: add time of day, clamp, zero on error
   logic signed [43:0]   sum;
   logic [ELAPSED_W-1:0] secs_in, secs_ff;
   logic                 ok_ff;
   err_type              err_ff;

   always_comb begin
      sum = 44'(prod_ff) + $signed({26'b0, ntod_ff}) - $signed({27'b0, btod4_ff});
      priority if (err4_ff != ERR_NONE) secs_in = '0;
      else if (sum[43])                 secs_in = '0;
      else if (sum[42:ELAPSED_W] != '0) secs_in = '1;
      else                              secs_in = sum[ELAPSED_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (flow.en[4]) begin
         secs_ff <= secs_in;
         err_ff  <= err4_ff;
         ok_ff   <= (err4_ff == ERR_NONE);
      end
   end

   assign date_ok         = ok_ff;
   assign error_kind      = err_ff;
   assign elapsed_seconds = secs_ff;

endmodule

>>> design/birth_date_check_elapsed_seconds_unit.sv
// Throughput: one request per cycle unless rsp_ stalls; five register stages,
// each with a valid bit, lie between request acceptance and the result on rsp_.
// The multiply by seconds-per-day has a stage of its own; stalls hold stages in place.
// Reset (synchronous): empties the pipeline and loads the current-moment registers
// with 1 January 2000, 00:00:00. No clearing pass follows reset.
module birth_date_check_elapsed_seconds_unit import bdce_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // birth_day[6:0], birth_month[13:7], birth_year[27:14],
                                    // birth_hour[34:28], birth_minute[41:35], zero fill
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // elapsed_seconds[37:0], zero fill
   output logic [3:0]  rsp_tuser,   // date_ok[0], error_kind[3:1]
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [2:0] REG_NOW_YEAR   = 3'd0;
   localparam logic [2:0] REG_NOW_MONTH  = 3'd1;
   localparam logic [2:0] REG_NOW_DOM    = 3'd2;
   localparam logic [2:0] REG_NOW_DOY    = 3'd3;
   localparam logic [2:0] REG_NOW_HOUR   = 3'd4;
   localparam logic [2:0] REG_NOW_MINUTE = 3'd5;
   localparam logic [2:0] REG_NOW_SECOND = 3'd6;

   // current moment, kept by software; write only while no request is in flight (the block does not enforce this)
   now_type    now_ff;
   now_type    now_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      now_in = now_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_NOW_YEAR:   now_in.year         = csr_pwdata[13:0];
            REG_NOW_MONTH:  now_in.month        = csr_pwdata[3:0];
            REG_NOW_DOM:    now_in.day_of_month = csr_pwdata[4:0];
            REG_NOW_DOY:    now_in.day_of_year  = csr_pwdata[8:0];
            REG_NOW_HOUR:   now_in.hour         = csr_pwdata[4:0];
            REG_NOW_MINUTE: now_in.minute       = csr_pwdata[5:0];
            REG_NOW_SECOND: now_in.second       = csr_pwdata[5:0];
            default: ;      // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff.year         <= 14'd2000;
         now_ff.month        <= 4'd1;
         now_ff.day_of_month <= 5'd1;
         now_ff.day_of_year  <= '0;
         now_ff.hour         <= '0;
         now_ff.minute       <= '0;
         now_ff.second       <= '0;
      end else begin
         now_ff <= now_in;
      end
   end

   // read back the selected register
   always_comb begin
      unique case (reg_idx)
         REG_NOW_YEAR:   csr_prdata = 32'(now_ff.year);
         REG_NOW_MONTH:  csr_prdata = 32'(now_ff.month);
         REG_NOW_DOM:    csr_prdata = 32'(now_ff.day_of_month);
         REG_NOW_DOY:    csr_prdata = 32'(now_ff.day_of_year);
         REG_NOW_HOUR:   csr_prdata = 32'(now_ff.hour);
         REG_NOW_MINUTE: csr_prdata = 32'(now_ff.minute);
         REG_NOW_SECOND: csr_prdata = 32'(now_ff.second);
         default:        csr_prdata = '0;
      endcase
   end

   // stage enables: each stage advances when empty or when the next one takes its request
   flow_type flow;

   bdce_flow u_flow (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .flow       (flow)
   );

   // stages 1 and 2: calendar checks, error code, leap counts and day of year
   front_type front;

   bdce_front u_front (
      .clock        (clock),
      .flow         (flow),
      .now_cfg      (now_ff),
      .birth_day    (req_tdata[6:0]),
      .birth_month  (req_tdata[13:7]),
      .birth_year   (req_tdata[27:14]),
      .birth_hour   (req_tdata[34:28]),
      .birth_minute (req_tdata[41:35]),
      .front_out    (front)
   );

   // stages 3 to 5: day count, seconds, clamp into the output register
   logic                 date_ok;
   err_type              error_kind;
   logic [ELAPSED_W-1:0] elapsed_seconds;

   bdce_back u_back (
      .clock           (clock),
      .flow            (flow),
      .now_cfg         (now_ff),
      .front_in        (front),
      .date_ok         (date_ok),
      .error_kind      (error_kind),
      .elapsed_seconds (elapsed_seconds)
   );

   assign rsp_tdata = {2'b00, elapsed_seconds};
   assign rsp_tuser = {error_kind, date_ok};

`ifndef SYNTHESIS
   a_ok_matches_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] == (rsp_tuser[3:1] == ERR_NONE)))
      else $error("date_ok disagrees with error_kind");
   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("elapsed seconds not zero on a rejected date");
   a_cfg_write: assert property (@(posedge clock) disable iff (reset)
      (wr_en && reg_idx == REG_NOW_YEAR) |=> (now_ff.year == $past(csr_pwdata[13:0])))
      else $error("now_year write lost");
`endif

endmodule
